// ===== rtl/cadc_pkg.sv =====
// shared types and constants for the calendar alarm due check
`timescale 1ns / 1ps

package cadc_pkg;

    // frequency modes
    localparam logic [1:0] MODE_DAILY    = 2'd0;
    localparam logic [1:0] MODE_WORKDAYS = 2'd1;
    localparam logic [1:0] MODE_WEEKLY   = 2'd2;
    localparam logic [1:0] MODE_HOURLY   = 2'd3;

    // register indexes on the configuration port
    localparam logic [2:0] REG_ENABLED         = 3'd0;
    localparam logic [2:0] REG_TARGET_HOUR     = 3'd1;
    localparam logic [2:0] REG_TARGET_MINUTE   = 3'd2;
    localparam logic [2:0] REG_FREQUENCY_MODE  = 3'd3;
    localparam logic [2:0] REG_WEEKLY_DAY      = 3'd4;
    localparam logic [2:0] REG_CATCH_UP_ENABLE = 3'd5;

    localparam int ADDR_WIDTH = 5;
    localparam int DATA_WIDTH = 32;

    // catch-up gap limits in seconds
    localparam int LIMIT_WIDTH = 20;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_HOURLY   = 20'd5400;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_DAILY    = 20'd129600;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_WORKDAYS = 20'd302400;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_WEEKLY   = 20'd648000;

    localparam logic [2:0] DAY_LAST   = 3'd6;
    localparam logic [2:0] WDAY_SUN   = 3'd0;
    localparam logic [2:0] WDAY_MON   = 3'd1;
    localparam logic [2:0] WDAY_FRI   = 3'd5;

    typedef struct packed {
        logic       enabled;
        logic [4:0] target_hour;
        logic [5:0] target_minute;
        logic [1:0] frequency_mode;
        logic [2:0] weekly_day;
        logic       catch_up_enable;
    } t_cfg;

    // monday-based day to sunday-based weekday, valid for days 0..6
    function automatic logic [2:0] monday_to_sunday(input logic [2:0] day);
        logic [2:0] wd;
        wd = (day == DAY_LAST) ? WDAY_SUN : day + 3'd1;
        return wd;
    endfunction

endpackage

// ===== rtl/cadc_cfg_regs.sv =====
// configuration register file behind the apb-style port
`timescale 1ns / 1ps

module cadc_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cadc_pkg::ADDR_WIDTH-1:0]    paddr,
    input  logic [cadc_pkg::DATA_WIDTH-1:0]    pwdata,
    output logic [cadc_pkg::DATA_WIDTH-1:0]    prdata,
    output logic                               pready,
    output cadc_pkg::t_cfg                     o_cfg
);

    cadc_pkg::t_cfg r_cfg;
    cadc_pkg::t_cfg n_cfg;
    logic [2:0]     reg_index;
    logic           wr_en;

    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign o_cfg     = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_index)
                cadc_pkg::REG_ENABLED:         n_cfg.enabled         = pwdata[0];
                cadc_pkg::REG_TARGET_HOUR:     n_cfg.target_hour     = pwdata[4:0];
                cadc_pkg::REG_TARGET_MINUTE:   n_cfg.target_minute   = pwdata[5:0];
                cadc_pkg::REG_FREQUENCY_MODE:  n_cfg.frequency_mode  = pwdata[1:0];
                cadc_pkg::REG_WEEKLY_DAY:      n_cfg.weekly_day      = pwdata[2:0];
                cadc_pkg::REG_CATCH_UP_ENABLE: n_cfg.catch_up_enable = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_index)
            cadc_pkg::REG_ENABLED:         prdata[0]   = r_cfg.enabled;
            cadc_pkg::REG_TARGET_HOUR:     prdata[4:0] = r_cfg.target_hour;
            cadc_pkg::REG_TARGET_MINUTE:   prdata[5:0] = r_cfg.target_minute;
            cadc_pkg::REG_FREQUENCY_MODE:  prdata[1:0] = r_cfg.frequency_mode;
            cadc_pkg::REG_WEEKLY_DAY:      prdata[2:0] = r_cfg.weekly_day;
            cadc_pkg::REG_CATCH_UP_ENABLE: prdata[0]   = r_cfg.catch_up_enable;
            default: ;
        endcase
    end

endmodule

// ===== rtl/cadc_due_logic.sv =====
// due decision and last-run record
`timescale 1ns / 1ps

module cadc_due_logic #(
    parameter int SECONDS_WIDTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  cadc_pkg::t_cfg           i_cfg,
    input  logic                     i_update,
    input  logic [SECONDS_WIDTH-1:0] i_now_seconds,
    input  logic [7:0]               i_now_year,
    input  logic [8:0]               i_now_day_of_year,
    input  logic [2:0]               i_now_weekday,
    input  logic [4:0]               i_now_hour,
    input  logic [5:0]               i_now_minute,
    output logic                     o_fire
);

    localparam int LIMIT_W = cadc_pkg::LIMIT_WIDTH;

    logic                     r_has_run;
    logic [SECONDS_WIDTH-1:0] r_last_seconds;
    logic [7:0]               r_last_year;
    logic [8:0]               r_last_day_of_year;
    logic [4:0]               r_last_hour;
    logic [5:0]               r_last_minute;

    logic                     hourly;
    logic                     same_date;
    logic                     blocked;
    logic                     eligible;
    logic                     reached;
    logic                     on_time;
    logic                     gap_ok;
    logic [LIMIT_W-1:0]       limit;
    logic [SECONDS_WIDTH-1:0] gap;

    assign hourly   = (i_cfg.frequency_mode == cadc_pkg::MODE_HOURLY);
    assign same_date = (r_last_year == i_now_year) && (r_last_day_of_year == i_now_day_of_year);

    always_comb begin
        if (hourly) begin
            blocked = same_date && (r_last_hour == i_now_hour)
                      && (r_last_minute >= i_cfg.target_minute);
        end else begin
            blocked = same_date && ((r_last_hour > i_cfg.target_hour)
                      || ((r_last_hour == i_cfg.target_hour)
                          && (r_last_minute >= i_cfg.target_minute)));
        end
        blocked = blocked && r_has_run;
    end

    always_comb begin
        case (i_cfg.frequency_mode)
            cadc_pkg::MODE_WORKDAYS: begin
                eligible = (i_now_weekday inside {[cadc_pkg::WDAY_MON:cadc_pkg::WDAY_FRI]});
            end
            cadc_pkg::MODE_WEEKLY: begin
                // a weekly day of 7 matches nothing
                eligible = (i_cfg.weekly_day <= cadc_pkg::DAY_LAST)
                           && (i_now_weekday == cadc_pkg::monday_to_sunday(i_cfg.weekly_day));
            end
            default: eligible = 1'b1;
        endcase
    end

    always_comb begin
        if (hourly) begin
            reached = (i_now_minute >= i_cfg.target_minute);
        end else begin
            reached = (i_now_hour > i_cfg.target_hour)
                      || ((i_now_hour == i_cfg.target_hour)
                          && (i_now_minute >= i_cfg.target_minute));
        end
        if (hourly || i_cfg.catch_up_enable) begin
            on_time = reached;
        end else begin
            on_time = (i_now_hour == i_cfg.target_hour)
                      && (i_now_minute >= i_cfg.target_minute);
        end
    end

    always_comb begin
        case (i_cfg.frequency_mode)
            cadc_pkg::MODE_DAILY:    limit = cadc_pkg::LIMIT_DAILY;
            cadc_pkg::MODE_WORKDAYS: limit = cadc_pkg::LIMIT_WORKDAYS;
            cadc_pkg::MODE_WEEKLY:   limit = cadc_pkg::LIMIT_WEEKLY;
            default:                 limit = cadc_pkg::LIMIT_HOURLY;
        endcase
    end

    // negative gap never counts
    assign gap    = i_now_seconds - r_last_seconds;
    assign gap_ok = (i_now_seconds >= r_last_seconds)
                    && (gap > SECONDS_WIDTH'(limit));

    assign o_fire = i_cfg.enabled && !blocked && eligible
                    && (on_time || (i_cfg.catch_up_enable && r_has_run && reached && gap_ok));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_run <= 1'b0;
        end else if (i_update && o_fire) begin
            r_has_run <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_update && o_fire) begin
            r_last_seconds     <= i_now_seconds;
            r_last_year        <= i_now_year;
            r_last_day_of_year <= i_now_day_of_year;
            r_last_hour        <= i_now_hour;
            r_last_minute      <= i_now_minute;
        end
    end

endmodule

// ===== rtl/calendar_alarm_due_check.sv =====
// top level: input register, due decision and result register
// path: an accepted item waits in the input register; its due decision then loads the result register
// throughput: one item per cycle while i_stall is low; the last-run record updates as the result register loads
// the next item sees the updated record, so items may arrive back to back
// reset: synchronous active-low, clears both valid flags, the config registers and has_run
`timescale 1ns / 1ps

module calendar_alarm_due_check #(
    parameter int SECONDS_WIDTH = 40
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [SECONDS_WIDTH-1:0]           i_now_seconds,
    input  logic [7:0]                         i_now_year,
    input  logic [8:0]                         i_now_day_of_year,
    input  logic [2:0]                         i_now_weekday,
    input  logic [4:0]                         i_now_hour,
    input  logic [5:0]                         i_now_minute,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_fire,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cadc_pkg::ADDR_WIDTH-1:0]    paddr,
    input  logic [cadc_pkg::DATA_WIDTH-1:0]    pwdata,
    output logic [cadc_pkg::DATA_WIDTH-1:0]    prdata,
    output logic                               pready
);

    cadc_pkg::t_cfg cfg;

    logic                     r_in_valid;
    logic [SECONDS_WIDTH-1:0] r_seconds;
    logic [7:0]               r_year;
    logic [8:0]               r_day_of_year;
    logic [2:0]               r_weekday;
    logic [4:0]               r_hour;
    logic [5:0]               r_minute;
    logic                     r_out_valid;
    logic                     r_fire;
    logic                     fire;
    logic                     advance;
    logic                     in_take;

    // item moves into the result register when that register is free or draining
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_fire  = r_fire;

    cadc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cadc_due_logic #(
        .SECONDS_WIDTH (SECONDS_WIDTH)
    ) u_due_logic (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_update          (advance),
        .i_now_seconds     (r_seconds),
        .i_now_year        (r_year),
        .i_now_day_of_year (r_day_of_year),
        .i_now_weekday     (r_weekday),
        .i_now_hour        (r_hour),
        .i_now_minute      (r_minute),
        .o_fire            (fire)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_seconds     <= i_now_seconds;
            r_year        <= i_now_year;
            r_day_of_year <= i_now_day_of_year;
            r_weekday     <= i_now_weekday;
            r_hour        <= i_now_hour;
            r_minute      <= i_now_minute;
        end
        if (advance) begin
            r_fire <= fire;
        end
    end

endmodule

// ===== sim/tb_calendar_alarm_due_check.sv =====
// testbench for the calendar alarm due check: directed schedules, then random calendar walks
`timescale 1ns / 1ps

module tb_calendar_alarm_due_check;

    localparam int SW                = 40;
    localparam int WATCHDOG_LIMIT    = 3000;
    localparam int CONFIGS_PER_PHASE = 8;
    localparam int ITEMS_PER_CONFIG  = 75;

    typedef struct packed {
        logic [SW-1:0] seconds;
        logic [7:0]    year;
        logic [8:0]    yday;
        logic [2:0]    wday;
        logic [4:0]    hour;
        logic [5:0]    minute;
    } t_check;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_stall;
    logic [SW-1:0]                   i_now_seconds;
    logic [7:0]                      i_now_year;
    logic [8:0]                      i_now_day_of_year;
    logic [2:0]                      i_now_weekday;
    logic [4:0]                      i_now_hour;
    logic [5:0]                      i_now_minute;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    logic                            o_fire;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [cadc_pkg::ADDR_WIDTH-1:0] paddr;
    logic [cadc_pkg::DATA_WIDTH-1:0] pwdata;
    logic [cadc_pkg::DATA_WIDTH-1:0] prdata;
    logic                            pready;

    // schedule as the block should hold it, and the last recorded run
    cadc_pkg::t_cfg alarm_cfg    = '0;
    logic           run_recorded = 1'b0;
    t_check         last_run     = '0;

    logic   expected_fire[$];
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     sent_count    = 0;
    int     checked_count = 0;
    int     fired_count   = 0;
    int     config_count  = 0;
    int     error_count   = 0;
    int     idle_cycles   = 0;
    longint cal_minutes   = 0;

    calendar_alarm_due_check #(
        .SECONDS_WIDTH(SW)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_now_seconds    (i_now_seconds),
        .i_now_year       (i_now_year),
        .i_now_day_of_year(i_now_day_of_year),
        .i_now_weekday    (i_now_weekday),
        .i_now_hour       (i_now_hour),
        .i_now_minute     (i_now_minute),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_fire           (o_fire),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // decides whether this time check fires and records the run if it does
    function automatic logic predict_fire(input t_check c);
        logic          hourly;
        logic          same_date;
        logic          blocked;
        logic          eligible;
        logic          reached;
        logic          fire;
        logic [3:0]    weekly_wday;
        logic [SW-1:0] gap;
        logic [SW-1:0] limit_sec;
        hourly = (alarm_cfg.frequency_mode == cadc_pkg::MODE_HOURLY);
        if (!alarm_cfg.enabled) return 1'b0;
        if (run_recorded) begin
            same_date = (last_run.year == c.year) && (last_run.yday == c.yday);
            if (hourly) begin
                blocked = same_date && last_run.hour == c.hour &&
                          last_run.minute >= alarm_cfg.target_minute;
            end else begin
                blocked = same_date && (last_run.hour > alarm_cfg.target_hour ||
                          (last_run.hour == alarm_cfg.target_hour &&
                           last_run.minute >= alarm_cfg.target_minute));
            end
            if (blocked) return 1'b0;
        end
        // weekly day is monday-based, the weekday field sunday-based
        weekly_wday = ({1'b0, alarm_cfg.weekly_day} + 4'd1) % 4'd7;
        case (alarm_cfg.frequency_mode)
            cadc_pkg::MODE_WORKDAYS: eligible = (c.wday >= cadc_pkg::WDAY_MON &&
                                                 c.wday <= cadc_pkg::WDAY_FRI);
            cadc_pkg::MODE_WEEKLY:   eligible = (alarm_cfg.weekly_day <= cadc_pkg::DAY_LAST) &&
                                                ({1'b0, c.wday} == weekly_wday);
            default:                 eligible = 1'b1;
        endcase
        if (!eligible) return 1'b0;
        if (hourly) begin
            reached = (c.minute >= alarm_cfg.target_minute);
        end else begin
            reached = (c.hour > alarm_cfg.target_hour) ||
                      (c.hour == alarm_cfg.target_hour && c.minute >= alarm_cfg.target_minute);
        end
        if (hourly || alarm_cfg.catch_up_enable) begin
            fire = reached;
        end else begin
            fire = (c.hour == alarm_cfg.target_hour && c.minute >= alarm_cfg.target_minute);
        end
        // late run when too long has passed since the last one; a negative gap never counts
        if (!fire && alarm_cfg.catch_up_enable && run_recorded && reached &&
            c.seconds >= last_run.seconds) begin
            gap = c.seconds - last_run.seconds;
            case (alarm_cfg.frequency_mode)
                cadc_pkg::MODE_DAILY:    limit_sec = SW'(cadc_pkg::LIMIT_DAILY);
                cadc_pkg::MODE_WORKDAYS: limit_sec = SW'(cadc_pkg::LIMIT_WORKDAYS);
                cadc_pkg::MODE_WEEKLY:   limit_sec = SW'(cadc_pkg::LIMIT_WEEKLY);
                default:                 limit_sec = SW'(cadc_pkg::LIMIT_HOURLY);
            endcase
            fire = (gap > limit_sec);
        end
        if (fire) begin
            run_recorded = 1'b1;
            last_run     = c;
        end
        return fire;
    endfunction

    // prediction on accepted items, checking of accepted results, watchdog
    always @(posedge i_clk) begin
        t_check accepted;
        logic   want;
        if (i_rst_n && i_valid && !o_stall) begin
            accepted = '{seconds: i_now_seconds, year: i_now_year, yday: i_now_day_of_year,
                         wday: i_now_weekday, hour: i_now_hour, minute: i_now_minute};
            expected_fire.push_back(predict_fire(accepted));
        end
        if (i_rst_n && o_valid && !i_stall) begin
            checked_count++;
            if (o_fire === 1'b1) fired_count++;
            if (expected_fire.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none actual fire=%b", $time, o_fire);
            end else begin
                want = expected_fire.pop_front();
                if (o_fire !== want) begin
                    error_count++;
                    $display("%0t: fire mismatch, expected %b actual %b", $time, want, o_fire);
                end
            end
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_check make_check(input longint seconds, input int year, input int yday,
                                          input int wday, input int hour, input int minute);
        t_check c;
        c.seconds = SW'(seconds);
        c.year    = 8'(year);
        c.yday    = 9'(yday);
        c.wday    = 3'(wday);
        c.hour    = 5'(hour);
        c.minute  = 6'(minute);
        return c;
    endfunction

    function automatic cadc_pkg::t_cfg make_cfg(input int en, input int hour, input int minute,
                                                input logic [1:0] mode, input int wday,
                                                input int catch_up);
        cadc_pkg::t_cfg c;
        c.enabled         = 1'(en);
        c.target_hour     = 5'(hour);
        c.target_minute   = 6'(minute);
        c.frequency_mode  = mode;
        c.weekly_day      = 3'(wday);
        c.catch_up_enable = 1'(catch_up);
        return c;
    endfunction

    task automatic send_check(input t_check c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_now_seconds     <= c.seconds;
        i_now_year        <= c.year;
        i_now_day_of_year <= c.yday;
        i_now_weekday     <= c.wday;
        i_now_hour        <= c.hour;
        i_now_minute      <= c.minute;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (checked_count != sent_count) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // upper bits of the write data are junk, the block keeps only the register width
    task automatic write_reg(input logic [2:0] idx, input int width, input logic [31:0] value);
        logic [31:0] junk;
        junk = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (junk << width) | value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic set_schedule(input cadc_pkg::t_cfg c);
        wait_idle();
        write_reg(cadc_pkg::REG_ENABLED,         1, 32'(c.enabled));
        write_reg(cadc_pkg::REG_TARGET_HOUR,     5, 32'(c.target_hour));
        write_reg(cadc_pkg::REG_TARGET_MINUTE,   6, 32'(c.target_minute));
        write_reg(cadc_pkg::REG_FREQUENCY_MODE,  2, 32'(c.frequency_mode));
        write_reg(cadc_pkg::REG_WEEKLY_DAY,      3, 32'(c.weekly_day));
        write_reg(cadc_pkg::REG_CATCH_UP_ENABLE, 1, 32'(c.catch_up_enable));
        psel      <= 1'b0;
        penable   <= 1'b0;
        alarm_cfg = c;
        config_count++;
    endtask

    // next time check: mostly a calendar walking forward, some jumps back and some noise
    task automatic next_calendar_check(output t_check c);
        int     pick;
        longint day;
        pick = $urandom_range(99);
        if (pick < 12) begin
            c.seconds = SW'({$urandom(), $urandom()});
            c.year    = 8'($urandom());
            c.yday    = 9'($urandom());
            c.wday    = 3'($urandom());
            c.hour    = 5'($urandom());
            c.minute  = 6'($urandom());
        end else begin
            if (pick < 55)      cal_minutes += $urandom_range(1, 20);
            else if (pick < 70) cal_minutes += 0;
            else if (pick < 84) cal_minutes += $urandom_range(30, 180);
            else if (pick < 95) cal_minutes += $urandom_range(1440, 14400);
            else                cal_minutes -= $urandom_range(1, 3000);
            day       = cal_minutes / 1440;
            c.seconds = SW'(cal_minutes * 60 + $urandom_range(0, 59));
            c.year    = 8'(70 + day / 365);
            c.yday    = 9'(day % 365);
            c.wday    = 3'((day + 4) % 7);
            c.hour    = 5'((cal_minutes / 60) % 24);
            c.minute  = 6'(cal_minutes % 60);
        end
    endtask

    task automatic test_disabled_at_reset();
        send_check(make_check(0, 0, 0, 0, 0, 0));
        send_check('1);
    endtask

    task automatic test_daily();
        set_schedule(make_cfg(1, 0, 0, cadc_pkg::MODE_DAILY, 0, 0));
        // a run at epoch zero still counts as recorded
        send_check(make_check(0, 0, 0, 0, 0, 0));
        send_check(make_check(0, 0, 0, 0, 0, 0));
        send_check(make_check(86400 + 1800, 0, 1, 1, 0, 30));
    endtask

    task automatic test_workdays();
        set_schedule(make_cfg(1, 23, 59, cadc_pkg::MODE_WORKDAYS, 0, 0));
        send_check(make_check(1000000, 120, 40, cadc_pkg::WDAY_SUN, 23, 59));
        send_check(make_check(1500000, 120, 45, cadc_pkg::WDAY_FRI, 23, 59));
        send_check(make_check(1600000, 120, 46, 7, 23, 59));
    endtask

    task automatic test_weekly();
        set_schedule(make_cfg(1, 12, 0, cadc_pkg::MODE_WEEKLY, cadc_pkg::DAY_LAST, 0));
        send_check(make_check(2000000, 121, 10, cadc_pkg::WDAY_SUN, 12, 5));
        send_check(make_check(2100000, 121, 16, 6, 12, 0));
        // weekly day beyond sunday matches no weekday at all
        set_schedule(make_cfg(1, 12, 0, cadc_pkg::MODE_WEEKLY, 7, 0));
        send_check(make_check(2700000, 121, 17, cadc_pkg::WDAY_SUN, 12, 0));
        send_check(make_check(2800000, 121, 18, cadc_pkg::WDAY_MON, 12, 0));
    endtask

    task automatic test_hourly();
        set_schedule(make_cfg(1, 31, 59, cadc_pkg::MODE_HOURLY, 3, 0));
        send_check(make_check(3000000, 122, 200, 3, 3, 59));
        send_check(make_check(3000010, 122, 200, 3, 3, 59));
        send_check(make_check(3000100, 122, 200, 3, 4, 58));
        send_check('1);
    endtask

    task automatic test_catch_up();
        set_schedule(make_cfg(1, 8, 0, cadc_pkg::MODE_DAILY, 0, 1));
        send_check(make_check(5000000, 123, 20, 2, 10, 0));
        // earlier clock than the last run: negative gap
        send_check(make_check(4000000, 123, 21, 3, 9, 0));
        send_check(make_check(5200000, 123, 22, 4, 9, 0));
        send_check(make_check(5201800, 123, 22, 4, 9, 30));
    endtask

    task automatic test_random_schedules();
        int             phase;
        int             k;
        int             n;
        cadc_pkg::t_cfg c;
        t_check         chk;
        cal_minutes = longint'($urandom_range(365, 365 * 60)) * 1440;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 15; recv_idle_pct = 69; end
                1:       begin send_idle_pct = 69; recv_idle_pct = 15; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            for (k = 0; k < CONFIGS_PER_PHASE; k++) begin
                c.enabled         = ($urandom_range(9) != 0);
                c.target_hour     = ($urandom_range(9) == 0) ? 5'($urandom_range(24, 31))
                                                              : 5'($urandom_range(0, 23));
                c.target_minute   = ($urandom_range(9) == 0) ? 6'($urandom_range(60, 63))
                                                              : 6'($urandom_range(0, 59));
                c.frequency_mode  = 2'(k);
                c.weekly_day      = 3'($urandom_range(0, 7));
                // first pass over the modes without catch-up, second pass with it
                c.catch_up_enable = 1'(k >> 2);
                set_schedule(c);
                for (n = 0; n < ITEMS_PER_CONFIG; n++) begin
                    next_calendar_check(chk);
                    send_check(chk);
                end
            end
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_valid           <= 1'b0;
        i_now_seconds     <= '0;
        i_now_year        <= '0;
        i_now_day_of_year <= '0;
        i_now_weekday     <= '0;
        i_now_hour        <= '0;
        i_now_minute      <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        send_idle_pct     = 15;
        recv_idle_pct     = 69;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_disabled_at_reset();
        test_daily();
        test_workdays();
        test_weekly();
        test_hourly();
        test_catch_up();
        test_random_schedules();
        wait_idle();

        if (expected_fire.size() != 0) begin
            error_count++;
            $display("%0t: %0d results never arrived", $time, expected_fire.size());
        end
        $display("checked %0d time checks under %0d schedules, %0d of them fired",
                 checked_count, config_count, fired_count);
        $display("all four modes ran with and without catch-up under three idle patterns");
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
